// ===== design/pfrc_pkg.sv =====
package pfrc_pkg;

	localparam int REGION_COUNT_DEF = 16;
	localparam int PAGE_BITS_DEF    = 12;

	localparam int ADDR_W      = 32;
	localparam int FLAGS_W     = 4;
	localparam int CODE_W      = 2;
	localparam int STATUS_W    = 3;
	localparam int PAGE_ADDR_W = 20;
	localparam int HIT_W       = 4;

	// flag bit positions
	localparam int FLAG_READ  = 0;
	localparam int FLAG_WRITE = 1;
	localparam int FLAG_EXEC  = 2;
	localparam int FLAG_STACK = 3;

	// fault code bit positions
	localparam int CODE_PRESENT = 0;
	localparam int CODE_WRITE   = 1;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_CHECK = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK            = 3'd0,
		ST_NO_REGION     = 3'd1,
		ST_READ_DENIED   = 3'd2,
		ST_WRITE_DENIED  = 3'd3,
		ST_LOAD_REJECTED = 3'd4
	} status_t;

endpackage

// ===== design/page_fault_region_check_core.sv =====
// Region table with page fault check.
//
// Request channel: drive the request fields and raise start; a request is
// taken at a rising edge where start is high and busy is low. operation
// selects a region load (writes or clears one table slot) or a fault check
// (finds the first valid slot whose end page lies above the faulting page and
// applies the stack guard and permission rules).
// Result channel: done is high for exactly one cycle with status,
// page_address, user_writable and hit_index; the receiver cannot stall it.
// Timing: a request passes the input register, then the result register, to done.
// Throughput: one request per cycle while busy is low; a check sees every
// load taken before it, since the table is written at the end of the
// input-register stage, where the check of the next request reads it. The
// per-cycle figure is set by the parallel compare over all slots and the
// priority pick in that stage.
// Reset: asynchronous, active low. It clears every valid bit at once, so no
// clearing pass follows; busy stays high for the first cycle after reset is
// released. Slot data is undefined until a load writes it and is only read
// through a valid slot.
module page_fault_region_check_core
	import pfrc_pkg::*;
#(
	parameter int REGION_COUNT = REGION_COUNT_DEF,
	parameter int PAGE_BITS    = PAGE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   operation,
	input  logic [HIT_W-1:0]       region_index,
	input  logic                   region_enable,
	input  logic [ADDR_W-1:0]      region_start,
	input  logic [ADDR_W-1:0]      region_end,
	input  logic [FLAGS_W-1:0]     region_flags,
	input  logic [ADDR_W-1:0]      fault_address,
	input  logic [CODE_W-1:0]      fault_code,
	output logic                   done,
	output logic [STATUS_W-1:0]    status,
	output logic [PAGE_ADDR_W-1:0] page_address,
	output logic                   user_writable,
	output logic [HIT_W-1:0]       hit_index
);

	// page number width and end page width (end may reach 2^PW)
	localparam int PW    = ADDR_W - PAGE_BITS;
	localparam int IDX_W = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
	localparam int SEL_W = (IDX_W > HIT_W) ? IDX_W : HIT_W;
	localparam logic [ADDR_W:0] PAGE_MASK = (ADDR_W+1)'((64'd1 << PAGE_BITS) - 64'd1);

	// ---------------- input register ----------------
	logic                 busy_q;
	logic                 req_s1;
	op_t                  op_s1;
	logic [HIT_W-1:0]     region_index_s1;
	logic                 region_enable_s1;
	logic [ADDR_W-1:0]    region_start_s1;
	logic [ADDR_W-1:0]    region_end_s1;
	logic [FLAGS_W-1:0]   region_flags_s1;
	logic [ADDR_W-1:0]    fault_address_s1;
	logic [CODE_W-1:0]    fault_code_s1;

	logic accept;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	// busy only covers the first cycle out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			req_s1 <= 1'b0;
		end else begin
			busy_q <= 1'b0;
			req_s1 <= accept;
		end
	end

	// hold the request payload; no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1            <= op_t'(operation);
			region_index_s1  <= region_index;
			region_enable_s1 <= region_enable;
			region_start_s1  <= region_start;
			region_end_s1    <= region_end;
			region_flags_s1  <= region_flags;
			fault_address_s1 <= fault_address;
			fault_code_s1    <= fault_code;
		end
	end

	// ---------------- region table ----------------
	logic [PW-1:0]      start_page_q [REGION_COUNT];
	logic [PW:0]        end_page_q   [REGION_COUNT];
	logic [FLAGS_W-1:0] flag_bits_q  [REGION_COUNT];
	logic [REGION_COUNT-1:0] entry_valid_q;

	// ---------------- load decode ----------------
	logic [SEL_W-1:0]  load_slot;
	logic              slot_bad;
	logic              load_rejected;
	logic              load_go;
	logic [ADDR_W:0]   end_round;
	logic [PW-1:0]     new_start_page;
	logic [PW:0]       new_end_page;

	assign load_slot      = SEL_W'(region_index_s1);
	assign slot_bad       = 32'(region_index_s1) >= 32'(REGION_COUNT);
	// a clear needs only a legal slot; a set also needs a non-empty range and flags
	assign load_rejected  = slot_bad ||
		(region_enable_s1 &&
		 ((region_start_s1 >= region_end_s1) || (region_flags_s1 == '0)));
	assign load_go        = req_s1 && (op_s1 == OP_LOAD) && !load_rejected;
	// round the end up to a page; the carry keeps the page just past the top
	assign end_round      = {1'b0, region_end_s1} + PAGE_MASK;
	assign new_start_page = region_start_s1[ADDR_W-1:PAGE_BITS];
	assign new_end_page   = end_round[ADDR_W:PAGE_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
		end else begin
			for (int i = 0; i < REGION_COUNT; i++) begin
				if (load_go && (load_slot == SEL_W'(i))) begin
					entry_valid_q[i] <= region_enable_s1;
				end
			end
		end
	end

	// slot data kept across a clear
	always_ff @(posedge clk) begin
		for (int i = 0; i < REGION_COUNT; i++) begin
			if (load_go && region_enable_s1 && (load_slot == SEL_W'(i))) begin
				start_page_q[i] <= new_start_page;
				end_page_q[i]   <= new_end_page;
				flag_bits_q[i]  <= region_flags_s1;
			end
		end
	end

	// ---------------- fault check ----------------
	logic [PW-1:0]           addr_page;
	logic [REGION_COUNT-1:0] cand;
	logic [REGION_COUNT-1:0] below;
	logic [REGION_COUNT-1:0] guard;
	logic [REGION_COUNT-1:0] first;
	logic                    hit_any;
	logic                    sel_below;
	logic                    sel_guard;
	logic [FLAGS_W-1:0]      sel_flags;
	logic [HIT_W-1:0]        sel_index;

	assign addr_page = fault_address_s1[ADDR_W-1:PAGE_BITS];

	// compare every slot against the faulting page in parallel
	always_comb begin
		for (int i = 0; i < REGION_COUNT; i++) begin
			cand[i]  = entry_valid_q[i] && (end_page_q[i] > {1'b0, addr_page});
			below[i] = start_page_q[i] > addr_page;
			guard[i] = flag_bits_q[i][FLAG_STACK] && (start_page_q[i] == addr_page);
		end
	end

	// lowest-numbered candidate wins; fields are picked through the one-hot mask
	always_comb begin
		logic seen;
		seen      = 1'b0;
		sel_below = 1'b0;
		sel_guard = 1'b0;
		sel_flags = '0;
		sel_index = '0;
		for (int i = 0; i < REGION_COUNT; i++) begin
			first[i] = cand[i] && !seen;
			seen     = seen || cand[i];
		end
		for (int i = 0; i < REGION_COUNT; i++) begin
			sel_below = sel_below | (first[i] & below[i]);
			sel_guard = sel_guard | (first[i] & guard[i]);
			sel_flags = sel_flags | ({FLAGS_W{first[i]}} & flag_bits_q[i]);
			sel_index = sel_index | ({HIT_W{first[i]}} & HIT_W'(i));
		end
		hit_any = seen;
	end

	// ---------------- result ----------------
	status_t                res_status;
	logic [PAGE_ADDR_W-1:0] res_page;
	logic                   res_wr;
	logic [HIT_W-1:0]       res_hit;
	logic [ADDR_W-1:0]      addr_shifted;

	assign addr_shifted = fault_address_s1 >> PAGE_BITS;

	always_comb begin
		res_status = ST_OK;
		res_page   = '0;
		res_wr     = 1'b0;
		res_hit    = '0;
		if (op_s1 == OP_LOAD) begin
			res_status = load_rejected ? ST_LOAD_REJECTED : ST_OK;
		end else begin
			priority if (!hit_any || sel_below) begin
				res_status = ST_NO_REGION;
			end else if (sel_guard) begin
				res_status = ST_READ_DENIED;
				res_hit    = sel_index;
			end else if (fault_code_s1[CODE_WRITE]) begin
				res_hit = sel_index;
				if (!sel_flags[FLAG_WRITE]) begin
					res_status = ST_WRITE_DENIED;
				end else begin
					res_page = addr_shifted[PAGE_ADDR_W-1:0];
					res_wr   = 1'b1;
				end
			end else begin
				res_hit = sel_index;
				// a read of a present page is a protection fault
				if (fault_code_s1[CODE_PRESENT] ||
				    !(sel_flags[FLAG_READ] || sel_flags[FLAG_EXEC])) begin
					res_status = ST_READ_DENIED;
				end else begin
					res_page = addr_shifted[PAGE_ADDR_W-1:0];
					res_wr   = sel_flags[FLAG_WRITE];
				end
			end
		end
	end

	logic                   done_s2;
	status_t                status_s2;
	logic [PAGE_ADDR_W-1:0] page_address_s2;
	logic                   user_writable_s2;
	logic [HIT_W-1:0]       hit_index_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= req_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_s1) begin
			status_s2        <= res_status;
			page_address_s2  <= res_page;
			user_writable_s2 <= res_wr;
			hit_index_s2     <= res_hit;
		end
	end

	assign done          = done_s2;
	assign status        = status_s2;
	assign page_address  = page_address_s2;
	assign user_writable = user_writable_s2;
	assign hit_index     = hit_index_s2;

	// ---------------- assertions ----------------
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(start && !busy, 2))
		else $error("result strobe does not follow an accepted request by two cycles");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |-> ((page_address == '0) && !user_writable))
		else $error("failed request reports a page or a writable mapping");

	a_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ((status == ST_NO_REGION) || (status == ST_LOAD_REJECTED)))
		|-> (hit_index == '0))
		else $error("hit index set without a matched region");

endmodule
